@@ hdl/ptl_pkg.sv @@
package ptl_pkg;

  // Default glyph grid
  localparam int GRID_COLS_DEF = 10;
  localparam int GRID_ROWS_DEF = 19;

  // Wide enough to compare any 8-bit entry against the largest grid (32 x 32)
  localparam int ENTRY_W = 11;

  // Character codes
  localparam logic [7:0] CODE_TAB         = 8'd9;
  localparam logic [7:0] CODE_NEWLINE     = 8'd10;
  localparam logic [7:0] CODE_NO_ADVANCE  = 8'd203;
  localparam logic [7:0] FIRST_GLYPH_CODE = 8'd32;

  // Request types
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LAYOUT = 1'b1;

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 2'd1;

  localparam logic [15:0] TAB_WIDTH_RST   = 16'd64;
  localparam logic [7:0]  LINE_HEIGHT_RST = 8'd16;

  typedef struct packed {
    logic       req_type;
    logic [7:0] glyph_index;
    logic [7:0] glyph_width;
    logic [7:0] char_code;
    logic       last;
  } ptl_in_t;

  typedef struct packed {
    logic [15:0] char_x;
    logic [15:0] char_y;
    logic [7:0]  advance;
    logic [15:0] string_width;
    logic [15:0] line_count;
    logic        is_last;
  } ptl_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_TAB,
    ST_COMMIT
  } ptl_state_t;

  // 16-bit add that sticks at all ones
  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

@@ hdl/proportional_text_layout_core.sv @@
// Proportional-font text layout core.
//
// Input channel (in_valid / in_stall / in_data): each transfer is either a
// glyph-width load (req_type 0) or one character to lay out (req_type 1).
// Loads write the glyph-width memory, produce no result and leave the input
// open. A character produces exactly one result on the output channel
// (out_valid / out_stall / out_data) with its pen position, advance, the
// running string width and the line count.
//
// Sequencing: a plain character, a newline or a zero-width tab reads the glyph
// memory at its transfer, then passes the lookup and commit states before its
// result is registered into out_data. A tab runs the bit-serial remainder
// unit (one bit per cycle, 16 bits) in the tab state, then commits. The input
// stays closed until the commit is done, so one character is worked at a time.
//
// The result sits in an output register; new items are taken while it waits.
// If the receiver stalls, the next finished character holds in the commit
// step until the output register frees. Reset restores tab_width = 64,
// line_height = 16 and the run state (x = 0, y = 0, one line); the glyph
// memory is not cleared and must be loaded before use.
module proportional_text_layout_core #(
  parameter int GRID_COLS = ptl_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = ptl_pkg::GRID_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ptl_pkg::ptl_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ptl_pkg::ptl_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [ptl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int GLYPH_COUNT = GRID_COLS * GRID_ROWS;
  localparam int AW          = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam logic [ptl_pkg::ENTRY_W-1:0] GLYPH_LIMIT = ptl_pkg::ENTRY_W'(GLYPH_COUNT);

  ptl_pkg::ptl_state_t state_r, state_nxt;

  // Configuration
  logic [15:0] tab_width_r;
  logic [7:0]  line_height_r;

  // Run state
  logic [15:0] cursor_x_r, cursor_x_nxt;
  logic [15:0] widest_x_r, widest_x_nxt;
  logic [15:0] line_y_r, line_y_nxt;
  logic [15:0] lines_seen_r, lines_seen_nxt;

  // Item being worked
  logic [7:0]  code_r;
  logic        last_r;
  logic        hit_r;
  logic [7:0]  adv_r, adv_nxt;
  logic [15:0] x_new_r, x_new_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  ptl_pkg::ptl_out_t    out_data_r, out_data_nxt;

  // Control
  logic in_xfer, load_xfer, char_xfer, tab_go;
  logic out_load;
  logic ram_we, ram_re;
  logic rem_done;
  logic [15:0] rem_val;
  logic [7:0]  ram_rdata;

  // Glyph lookup address
  logic [7:0]                 entry;
  logic [ptl_pkg::ENTRY_W-1:0] entry_w, gidx_w;
  logic                       entry_hit, gidx_hit;

  assign in_xfer   = in_valid && !in_stall;
  assign load_xfer = in_xfer && (in_data.req_type == ptl_pkg::REQ_LOAD);
  assign char_xfer = in_xfer && (in_data.req_type == ptl_pkg::REQ_LAYOUT);
  assign tab_go    = char_xfer && (in_data.char_code == ptl_pkg::CODE_TAB) &&
                     (tab_width_r != 16'd0);

  assign entry     = in_data.char_code - ptl_pkg::FIRST_GLYPH_CODE;
  assign entry_w   = ptl_pkg::ENTRY_W'(entry);
  assign gidx_w    = ptl_pkg::ENTRY_W'(in_data.glyph_index);
  assign entry_hit = entry_w < GLYPH_LIMIT;
  assign gidx_hit  = gidx_w < GLYPH_LIMIT;

  assign ram_we = load_xfer && gidx_hit;
  assign ram_re = char_xfer;

  ptl_ram #(
    .WIDTH (8),
    .DEPTH (GLYPH_COUNT)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (gidx_w[AW-1:0]),
    .wdata (in_data.glyph_width),
    .re    (ram_re),
    .raddr (entry_w[AW-1:0]),
    .rdata (ram_rdata)
  );

  ptl_rem u_tab_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (tab_go),
    .dividend  (cursor_x_r),
    .divisor   (tab_width_r),
    .done      (rem_done),
    .remainder (rem_val)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptl_pkg::ST_IDLE: begin
        if (tab_go) begin
          state_nxt = ptl_pkg::ST_TAB;
        end else if (char_xfer) begin
          state_nxt = ptl_pkg::ST_LOOKUP;
        end
      end
      ptl_pkg::ST_LOOKUP: begin
        state_nxt = ptl_pkg::ST_COMMIT;
      end
      ptl_pkg::ST_TAB: begin
        if (rem_done) begin
          state_nxt = ptl_pkg::ST_COMMIT;
        end
      end
      ptl_pkg::ST_COMMIT: begin
        if (out_load) begin
          state_nxt = ptl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ptl_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state_r)
      ptl_pkg::ST_IDLE:   in_stall = 1'b0;
      ptl_pkg::ST_LOOKUP: in_stall = 1'b1;
      ptl_pkg::ST_TAB:    in_stall = 1'b1;
      ptl_pkg::ST_COMMIT: out_load = !out_valid_r || !out_stall;
      default:            in_stall = 1'b1;
    endcase
  end

  // Work out the new pen x and advance
  always_comb begin
    logic [16:0] tab_sum;
    adv_nxt   = adv_r;
    x_new_nxt = x_new_r;
    tab_sum   = '0;
    if (state_r == ptl_pkg::ST_LOOKUP) begin
      if (code_r == ptl_pkg::CODE_NEWLINE) begin
        adv_nxt   = 8'd0;
        x_new_nxt = 16'd0;
      end else if (code_r == ptl_pkg::CODE_TAB) begin
        // zero tab width: pen stays put
        adv_nxt   = 8'd0;
        x_new_nxt = cursor_x_r;
      end else begin
        adv_nxt   = hit_r ? ram_rdata : 8'd0;
        x_new_nxt = (code_r == ptl_pkg::CODE_NO_ADVANCE) ? cursor_x_r :
                    ptl_pkg::sat_add16(cursor_x_r, {8'd0, adv_nxt});
      end
    end else if (state_r == ptl_pkg::ST_TAB && rem_done) begin
      adv_nxt   = 8'd0;
      tab_sum   = {1'b0, cursor_x_r} + {1'b0, tab_width_r - rem_val};
      x_new_nxt = tab_sum[16] ? 16'hFFFF : tab_sum[15:0];
    end
  end

  // Commit: build the result and update the run state
  always_comb begin
    logic        is_nl;
    logic [15:0] widest_line;
    logic [15:0] sw;
    is_nl          = (code_r == ptl_pkg::CODE_NEWLINE);
    widest_line    = (is_nl && (cursor_x_r > widest_x_r)) ? cursor_x_r : widest_x_r;
    sw             = (x_new_r > widest_line) ? x_new_r : widest_line;
    line_y_nxt     = is_nl ? ptl_pkg::sat_add16(line_y_r, {8'd0, line_height_r}) : line_y_r;
    lines_seen_nxt = is_nl ? ptl_pkg::sat_add16(lines_seen_r, 16'd1) : lines_seen_r;
    cursor_x_nxt   = x_new_r;
    widest_x_nxt   = widest_line;

    out_data_nxt.char_x       = cursor_x_r;
    out_data_nxt.char_y       = line_y_r;
    out_data_nxt.advance      = adv_r;
    out_data_nxt.string_width = sw;
    out_data_nxt.line_count   = lines_seen_nxt;
    out_data_nxt.is_last      = last_r;

    // Drop the run back to its start values after the final character
    if (last_r) begin
      cursor_x_nxt   = 16'd0;
      widest_x_nxt   = 16'd0;
      line_y_nxt     = 16'd0;
      lines_seen_nxt = 16'd1;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ptl_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      tab_width_r   <= ptl_pkg::TAB_WIDTH_RST;
      line_height_r <= ptl_pkg::LINE_HEIGHT_RST;
      cursor_x_r    <= 16'd0;
      widest_x_r    <= 16'd0;
      line_y_r      <= 16'd0;
      lines_seen_r  <= 16'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ptl_pkg::CFG_TAB_WIDTH:   tab_width_r   <= cfg_wdata[15:0];
          ptl_pkg::CFG_LINE_HEIGHT: line_height_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_load) begin
        cursor_x_r   <= cursor_x_nxt;
        widest_x_r   <= widest_x_nxt;
        line_y_r     <= line_y_nxt;
        lines_seen_r <= lines_seen_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (char_xfer) begin
      code_r <= in_data.char_code;
      last_r <= in_data.last;
      hit_r  <= entry_hit;
    end
    adv_r   <= adv_nxt;
    x_new_r <= x_new_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/ptl_ram.sv @@
module ptl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 190
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/ptl_rem.sv @@
module ptl_rem (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] remainder
);

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] dvd_r, dvd_nxt;
  logic [15:0] div_r, div_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] trial;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dvd_r[15]};
    if (trial >= {1'b0, div_r}) begin
      trial = trial - {1'b0, div_r};
    end
  end

  // Advance the bit-serial remainder
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd16;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
        dvd_nxt = {dvd_r[14:0], 1'b0};
        rem_nxt = trial[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = busy_r && (cnt_r == 5'd0);
  assign remainder = rem_r;

endmodule

@@ hdl/ptl_checker.sv @@
module ptl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input ptl_pkg::ptl_in_t                in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input ptl_pkg::ptl_out_t               out_data,
  input logic                            cfg_we,
  input logic [ptl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [ptl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A character keeps the input closed while it is worked
  a_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == ptl_pkg::REQ_LAYOUT) |=> in_stall)
    else $error("input open right after a character transfer");

  // A glyph load never raises a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == ptl_pkg::REQ_LOAD) && !out_valid
    |=> !out_valid)
    else $error("result appeared after a glyph load");

  // The line count starts at one and saturates, so it is never zero
  a_lines_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.line_count != 16'd0)
    else $error("line count is zero");

  // Nonzero tab-width write, used by the check below
  logic cfg_seen;
  assign cfg_seen = cfg_we && (cfg_index == ptl_pkg::CFG_TAB_WIDTH) && (cfg_wdata != '0);

  // A tab width of zero is legal; just confirm nonzero tab-width writes do not disturb a waiting result
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_seen && out_valid && out_stall |=> out_valid)
    else $error("configuration write dropped a result");

endmodule

bind proportional_text_layout_core ptl_checker u_ptl_checker (.*);

@@ dv/proportional_text_layout_core_tb.sv @@
module proportional_text_layout_core_tb;

  localparam int GLYPHS = ptl_pkg::GRID_COLS_DEF * ptl_pkg::GRID_ROWS_DEF;
  localparam int IDLE_PCT = 33;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT = 4000;
  // Register slots past the end of the list; writes there must be dropped
  localparam logic [ptl_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [ptl_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  ptl_pkg::ptl_in_t               in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  ptl_pkg::ptl_out_t              out_data;
  logic                           cfg_we = 1'b0;
  logic [ptl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ptl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Layout model state
  logic [7:0]  glyph_tbl [0:GLYPHS-1];
  logic [15:0] pen_x = '0;
  logic [15:0] pen_y = '0;
  logic [15:0] widest = '0;
  logic [15:0] lines = 16'd1;
  logic [15:0] tab_w = ptl_pkg::TAB_WIDTH_RST;
  logic [7:0]  line_h = ptl_pkg::LINE_HEIGHT_RST;

  ptl_pkg::ptl_in_t  pending_requests [$];
  ptl_pkg::ptl_out_t expected_layouts [$];
  int       errors = 0;
  int       quiet_cycles = 0;
  bit       steady = 1'b0;

  proportional_text_layout_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  initial begin
    for (int i = 0; i < GLYPHS; i++) glyph_tbl[i] = '0;
  end

  function automatic logic [15:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
  endfunction

  // Apply one transfer to the layout state; queue the result a character produces
  task automatic predict_layout(input ptl_pkg::ptl_in_t item);
    ptl_pkg::ptl_out_t res;
    logic [7:0]        entry;
    if (item.req_type == ptl_pkg::REQ_LOAD) begin
      if (item.glyph_index < GLYPHS) glyph_tbl[item.glyph_index] = item.glyph_width;
    end else begin
      res = '0;
      res.char_x = pen_x;
      res.char_y = pen_y;
      if (item.char_code == ptl_pkg::CODE_NEWLINE) begin
        if (pen_x > widest) widest = pen_x;
        pen_x = '0;
        pen_y = add_sat(pen_y, line_h);
        lines = add_sat(lines, 1);
      end else if (item.char_code == ptl_pkg::CODE_TAB) begin
        if (tab_w != 0) pen_x = add_sat(pen_x, tab_w - (pen_x % tab_w));
      end else begin
        entry = item.char_code - ptl_pkg::FIRST_GLYPH_CODE;
        res.advance = (entry < GLYPHS) ? glyph_tbl[entry] : 8'd0;
        if (item.char_code != ptl_pkg::CODE_NO_ADVANCE) pen_x = add_sat(pen_x, res.advance);
      end
      res.string_width = (pen_x > widest) ? pen_x : widest;
      res.line_count = lines;
      res.is_last = item.last;
      expected_layouts.push_back(res);
      // Closing character: start the next string from scratch
      if (item.last) begin
        pen_x = '0;
        pen_y = '0;
        widest = '0;
        lines = 16'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp, act);
      errors++;
    end
  endtask

  task automatic check_layout(input ptl_pkg::ptl_out_t got);
    ptl_pkg::ptl_out_t exp;
    if (expected_layouts.size() == 0) begin
      $display("%0t: unexpected result expected none, got %h", $time, got);
      errors++;
    end else begin
      exp = expected_layouts.pop_front();
      check_field("char_x", exp.char_x, got.char_x);
      check_field("char_y", exp.char_y, got.char_y);
      check_field("advance", exp.advance, got.advance);
      check_field("string_width", exp.string_width, got.string_width);
      check_field("line_count", exp.line_count, got.line_count);
      check_field("is_last", exp.is_last, got.is_last);
    end
  endtask

  // Input side: predict on each transfer, hold while stalled, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      in_valid <= 1'b1;
    end else begin
      if (in_valid) predict_layout(in_data);
      if (pending_requests.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data <= pending_requests.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_layout(out_data);
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Abort when neither channel has moved for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("proportional_text_layout_core: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_load(input int idx, input int width);
    ptl_pkg::ptl_in_t item;
    item.req_type = ptl_pkg::REQ_LOAD;
    item.glyph_index = 8'(idx);
    item.glyph_width = 8'(width);
    item.char_code = 8'($urandom_range(0, 255));
    item.last = 1'($urandom_range(0, 1));
    pending_requests.push_back(item);
  endtask

  task automatic push_char(input logic [7:0] code, input logic last);
    ptl_pkg::ptl_in_t item;
    item.req_type = ptl_pkg::REQ_LAYOUT;
    item.glyph_index = 8'($urandom_range(0, 255));
    item.glyph_width = 8'($urandom_range(0, 255));
    item.char_code = code;
    item.last = last;
    pending_requests.push_back(item);
  endtask

  function automatic logic [7:0] pick_code(input int nl_pct);
    int r;
    if ($urandom_range(0, 99) < nl_pct) return ptl_pkg::CODE_NEWLINE;
    r = $urandom_range(0, 99);
    if (r < 9) return ptl_pkg::CODE_TAB;
    if (r < 13) return ptl_pkg::CODE_NO_ADVANCE;
    // Control bytes and the codes above the grid have no glyph
    if (r < 17) return 8'($urandom_range(0, ptl_pkg::FIRST_GLYPH_CODE - 1));
    if (r < 20) return 8'($urandom_range(ptl_pkg::FIRST_GLYPH_CODE + GLYPHS, 255));
    return 8'($urandom_range(ptl_pkg::FIRST_GLYPH_CODE,
                             ptl_pkg::FIRST_GLYPH_CODE + GLYPHS - 1));
  endfunction

  // Wait until every request has gone in and every result has come back
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_layouts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ptl_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == ptl_pkg::CFG_TAB_WIDTH) tab_w = val;
    else if (idx == ptl_pkg::CFG_LINE_HEIGHT) line_h = val[7:0];
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] tw, input logic [7:0] lh, input int n,
                           input int nl_pct, input int last_pct, input int load_pct);
    wait_idle();
    write_reg(ptl_pkg::CFG_TAB_WIDTH, tw);
    write_reg(ptl_pkg::CFG_LINE_HEIGHT, {8'h00, lh});
    cfg_we <= 1'b0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < load_pct)
        push_load($urandom_range(0, 255), $urandom_range(0, 255));
      else
        push_char(pick_code(nl_pct), $urandom_range(0, 99) < last_pct);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: load only the glyphs used below
    push_load(33, 8);             // 'A'
    push_load(0, 0);              // space, zero width
    push_load(GLYPHS - 1, 255);   // last grid cell, widest glyph
    push_load(ptl_pkg::CODE_NO_ADVANCE - ptl_pkg::FIRST_GLYPH_CODE, 200);
    push_load(94, 170);           // '~'
    push_load(GLYPHS, 77);        // just past the grid: dropped
    push_load(255, 255);          // far past the grid: dropped
    push_char(8'd65, 1'b0);
    push_char(ptl_pkg::FIRST_GLYPH_CODE, 1'b0);
    push_char(ptl_pkg::CODE_TAB, 1'b0);
    push_char(ptl_pkg::CODE_TAB, 1'b0);    // already on a stop: move a full stop
    push_char(8'd65, 1'b0);
    push_char(ptl_pkg::CODE_NO_ADVANCE, 1'b0);
    push_char(8'(ptl_pkg::FIRST_GLYPH_CODE + GLYPHS - 1), 1'b0);
    push_char(8'd126, 1'b0);
    push_char(8'd0, 1'b0);
    push_char(8'd255, 1'b0);
    push_char(8'(ptl_pkg::FIRST_GLYPH_CODE + GLYPHS), 1'b0);
    push_char(8'(ptl_pkg::FIRST_GLYPH_CODE - 1), 1'b0);
    push_char(ptl_pkg::CODE_NEWLINE, 1'b0);
    push_char(ptl_pkg::CODE_TAB, 1'b0);
    push_char(8'(ptl_pkg::FIRST_GLYPH_CODE + GLYPHS - 1), 1'b0);
    push_char(8'd65, 1'b1);
    push_char(ptl_pkg::CODE_NEWLINE, 1'b1);
    push_char(ptl_pkg::CODE_NO_ADVANCE, 1'b1);

    // Fill the whole font so any in-grid code is legal from here on
    wait_idle();
    for (int i = 0; i < GLYPHS; i++) push_load(i, $urandom_range(0, 255));

    // Register extremes
    run_phase(16'd1, 8'd0, 150, 8, 5, 10);
    run_phase(16'hFFFF, 8'd255, 150, 8, 5, 10);

    // Dropped writes to the unused slots, then a zero tab width
    wait_idle();
    write_reg(CFG_SPARE_2, 16'($urandom_range(0, 65535)));
    write_reg(CFG_SPARE_3, 16'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
    run_phase(16'd0, 8'd7, 100, 8, 5, 10);

    // One long string: mostly newlines to pin y, then no newlines to pin x
    run_phase(16'd40000, 8'd255, 340, 90, 0, 2);
    run_phase(16'd40000, 8'd255, 80, 0, 0, 2);

    // Random settings, one phase without any idling on either side
    for (int p = 0; p < 6; p++) begin
      steady = (p == 2);
      run_phase((p == 4) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 300)),
                8'($urandom_range(0, 255)), 160, 8, 5, 8);
    end

    wait_idle();
    if (errors == 0) begin
      $display("proportional_text_layout_core: match");
    end else begin
      $display("proportional_text_layout_core: mismatch");
    end
    $finish;
  end

endmodule
